@@ sv/sva_pkg.sv @@
// Shared types, constants and helper functions of the voice assigner.
package sva_pkg;

  localparam int VOICES    = 6;
  localparam int KEYS      = 128;
  localparam int VIDX_W    = 3;
  localparam int KEY_W     = 7;
  localparam int KC_W      = KEY_W + 1;
  localparam int NOTE_W    = 8;
  localparam int TIME_W    = 32;
  localparam int VEL_W     = 16;
  localparam int FLAG_W    = 4;
  localparam int PAT_BYTES = 6;
  localparam int PAT_SLOTS = (VOICES < PAT_BYTES) ? VOICES : PAT_BYTES;
  localparam int PAT_W     = 3;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;

  localparam logic [NOTE_W-1:0] NO_NOTE   = 8'hFF;
  localparam logic [NOTE_W-1:0] OFF_END   = 8'hFF;
  localparam logic [TIME_W-1:0] TIME_NONE = '1;

  localparam int FL_ALLOC    = 0;
  localparam int FL_GATED    = 1;
  localparam int FL_PRESSED  = 2;
  localparam int FL_FROMKEYS = 3;

  typedef enum logic [2:0] {
    OP_NOTE   = 3'd0,
    OP_DONE   = 3'd1,
    OP_ALLOFF = 3'd2,
    OP_HOLD   = 3'd3,
    OP_PANIC  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PRIO_LAST = 2'd0,
    PRIO_LOW  = 2'd1,
    PRIO_HIGH = 2'd2
  } prio_e;

  typedef enum logic [1:0] {
    REG_PRIO = 2'd0,
    REG_MASK = 2'd1,
    REG_MONO = 2'd2,
    REG_PAT  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    VS_FREE   = 2'd0,
    VS_STEAL1 = 2'd1,
    VS_STEAL2 = 2'd2
  } vscan_e;

  typedef enum logic {
    KS_MONO = 1'b0,
    KS_OFF  = 1'b1
  } kscan_e;

  typedef enum logic [1:0] {
    SW_OFF     = 2'd0,
    SW_ALLOFF  = 2'd1,
    SW_RELEASE = 2'd2
  } sweep_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GON,
    S_VSCAN,
    S_VPICK,
    S_KSCAN,
    S_KDONE,
    S_NOFF,
    S_PATTERN,
    S_SWEEP
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  key_number;
    logic        key_down;
    logic [15:0] strike_velocity;
    logic        from_keys;
    logic [2:0]  voice_index;
    logic        hold_on;
    logic [31:0] tick;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_note;
    logic        out_gate;
    logic [2:0]  out_voice;
    logic [15:0] out_velocity;
    logic        out_legato;
    logic        out_last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  priority_mode;
    logic [5:0]  voice_enable_mask;
    logic        mono_mode;
    logic [47:0] pattern_offsets;
  } cfg_t;

  typedef struct packed {
    logic              latch;
    logic              key_write;
    logic              voice_done;
    logic              alloff_clear;
    logic              hold_set;
    logic              panic;
    logic              gon_init;
    logic              restore;
    logic              set_v0;
    logic              pick_v;
    logic              vs_init;
    logic              vs_step;
    vscan_e            vs_mode;
    logic [VIDX_W-1:0] v_idx;
    logic              ks_init;
    logic              ks_issue;
    kscan_e            ks_mode;
    logic [KEY_W-1:0]  ks_addr;
    logic              sw_step;
    sweep_e            sw_kind;
    logic              pat_emit;
    logic [PAT_W-1:0]  pat_idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        op;
    logic              key_down;
    logic              hold_on;
    logic              any_en;
    logic              out_free;
    logic              root_hit;
    logic              pick_ok;
    logic              ks_found;
    logic              ks_abort;
    logic [VOICES-1:0] sw_qual;
    logic              sw_emit;
    logic [PAT_W-1:0]  pat_len;
  } sts_t;

  // Priority code three behaves as last-note priority.
  function automatic prio_e prio_norm(input logic [1:0] code);
    prio_e p;
    unique case (code)
      2'd1:    p = PRIO_LOW;
      2'd2:    p = PRIO_HIGH;
      default: p = PRIO_LAST;
    endcase
    return p;
  endfunction

  function automatic logic [PAT_W-1:0] pat_len(input logic [47:0] pat);
    logic [PAT_W-1:0] n;
    logic             stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < PAT_SLOTS; i++) begin
      if (!stop) begin
        if (pat[8*i +: 8] == OFF_END) stop = 1'b1;
        else n = n + 1'b1;
      end
    end
    return n;
  endfunction

  // Next enabled voice after v, wrapping around.
  function automatic logic [VIDX_W-1:0] next_voice(input logic [VIDX_W-1:0] v,
                                                   input logic [VOICES-1:0] en);
    logic [VIDX_W-1:0] r;
    logic [VIDX_W-1:0] c;
    logic              hit;
    r   = v;
    c   = v;
    hit = 1'b0;
    for (int s = 0; s < VOICES; s++) begin
      c = (c == VIDX_W'(VOICES - 1)) ? '0 : c + 1'b1;
      if (!hit && en[c]) begin
        r   = c;
        hit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ sv/sva_regs.sv @@
// APB configuration registers of the voice assigner.
module sva_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sva_pkg::ADDR_W-1:0] paddr,
  input  logic [sva_pkg::DATA_W-1:0] pwdata,
  output logic [sva_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sva_pkg::cfg_t              cfg_o
);

  sva_pkg::cfg_t cfg_q;
  sva_pkg::reg_e sel;
  logic          wr;

  assign sel    = sva_pkg::reg_e'(paddr[sva_pkg::ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.priority_mode     <= 2'd0;
      cfg_q.voice_enable_mask <= 6'h3F;
      cfg_q.mono_mode         <= 1'b0;
      cfg_q.pattern_offsets   <= 48'hFFFF_FFFF_FF00;
    end else if (wr) begin
      unique case (sel)
        sva_pkg::REG_PRIO: cfg_q.priority_mode     <= pwdata[1:0];
        sva_pkg::REG_MASK: cfg_q.voice_enable_mask <= pwdata[5:0];
        sva_pkg::REG_MONO: cfg_q.mono_mode         <= pwdata[0];
        sva_pkg::REG_PAT:  cfg_q.pattern_offsets   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      sva_pkg::REG_PRIO: prdata[1:0]  = cfg_q.priority_mode;
      sva_pkg::REG_MASK: prdata[5:0]  = cfg_q.voice_enable_mask;
      sva_pkg::REG_MONO: prdata[0]    = cfg_q.mono_mode;
      sva_pkg::REG_PAT:  prdata[47:0] = cfg_q.pattern_offsets;
      default: ;
    endcase
  end

endmodule

@@ sv/sva_datapath.sv @@
// Datapath: key table, voice state, search accumulators and output register.
module sva_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sva_pkg::cfg_t       cfg_i,
  input  sva_pkg::cmd_t       cmd_i,
  output sva_pkg::sts_t       sts_o,
  input  sva_pkg::in_word_t   in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output sva_pkg::out_word_t  out_data_o
);

  localparam int TV_W = sva_pkg::TIME_W + sva_pkg::VEL_W;

  logic [sva_pkg::VOICES-1:0]   en;
  sva_pkg::prio_e               prio;
  sva_pkg::in_word_t            lat_q;

  logic [sva_pkg::KEYS-1:0]     held_q;
  logic [TV_W-1:0]              kmem [sva_pkg::KEYS];
  logic [TV_W-1:0]              krd_q;
  logic [sva_pkg::KEY_W-1:0]    sk;
  logic                         ev_en_q;
  logic [sva_pkg::KEY_W-1:0]    ev_key_q;
  logic [sva_pkg::TIME_W-1:0]   krd_time;
  logic [sva_pkg::VEL_W-1:0]    krd_vel;

  logic [sva_pkg::TIME_W-1:0]   vtime_q [sva_pkg::VOICES];
  logic [sva_pkg::VEL_W-1:0]    vvel_q  [sva_pkg::VOICES];
  logic [sva_pkg::NOTE_W-1:0]   vroot_q [sva_pkg::VOICES];
  logic [sva_pkg::NOTE_W-1:0]   vnote_q [sva_pkg::VOICES];
  logic [sva_pkg::FLAG_W-1:0]   vflag_q [sva_pkg::VOICES];
  logic                         hold_q;

  logic [sva_pkg::KEY_W-1:0]    g_note_q;
  logic [sva_pkg::VEL_W-1:0]    g_vel_q;
  logic                         g_leg_q;
  logic [sva_pkg::VIDX_W-1:0]   cur_v_q;

  logic                         fm_found_q;
  logic [sva_pkg::VIDX_W-1:0]   fm_v_q;
  logic                         acc_found_q;
  logic [sva_pkg::VIDX_W-1:0]   acc_v_q;
  logic [sva_pkg::TIME_W-1:0]   acc_time_q;
  logic [sva_pkg::NOTE_W-1:0]   acc_note_q;

  logic                         ks_found_q;
  logic                         ks_abort_q;
  logic [sva_pkg::KEY_W-1:0]    ks_key_q;
  logic [sva_pkg::VEL_W-1:0]    ks_vel_q;
  logic [sva_pkg::TIME_W-1:0]   ks_ts_q;

  logic [sva_pkg::VOICES-1:0]   root_hit_v;
  logic [sva_pkg::VOICES-1:0]   ev_rooted_v;
  logic [sva_pkg::VOICES-1:0]   qual;
  logic                         sw_emit;
  logic                         sw_last;
  logic [sva_pkg::PAT_W-1:0]    plen;
  logic [sva_pkg::NOTE_W-1:0]   off;
  logic [sva_pkg::NOTE_W-1:0]   played;
  logic [sva_pkg::VIDX_W-1:0]   sv;
  logic                         sw_fire;
  logic                         emit;
  logic                         vi_ok;
  logic                         root_held;
  sva_pkg::out_word_t           out_d;
  sva_pkg::out_word_t           out_q;
  logic                         out_valid_q;

  assign en       = cfg_i.voice_enable_mask[sva_pkg::VOICES-1:0];
  assign prio     = sva_pkg::prio_norm(cfg_i.priority_mode);
  assign plen     = sva_pkg::pat_len(cfg_i.pattern_offsets);
  assign krd_time = krd_q[TV_W-1:sva_pkg::VEL_W];
  assign krd_vel  = krd_q[sva_pkg::VEL_W-1:0];
  assign sv       = cmd_i.v_idx;
  assign vi_ok    = {1'b0, lat_q.voice_index} < 4'(sva_pkg::VOICES);
  assign off      = cfg_i.pattern_offsets[8*cmd_i.pat_idx +: 8];
  assign played   = {1'b0, g_note_q} + off;
  assign root_held = !vroot_q[sv][sva_pkg::NOTE_W-1] &&
                     held_q[vroot_q[sv][sva_pkg::KEY_W-1:0]];

  // In note-off scans, high-note priority walks the keys from the top.
  assign sk = (cmd_i.ks_mode == sva_pkg::KS_OFF && prio == sva_pkg::PRIO_HIGH) ?
              ~cmd_i.ks_addr : cmd_i.ks_addr;

  always_comb begin
    for (int v = 0; v < sva_pkg::VOICES; v++) begin
      root_hit_v[v]  = en[v] && vflag_q[v][sva_pkg::FL_ALLOC] &&
                       (vroot_q[v] == {1'b0, lat_q.key_number});
      ev_rooted_v[v] = en[v] && vflag_q[v][sva_pkg::FL_ALLOC] &&
                       (vroot_q[v] == {1'b0, ev_key_q});
      unique case (cmd_i.sw_kind)
        sva_pkg::SW_ALLOFF:  qual[v] = en[v] && vflag_q[v][sva_pkg::FL_GATED] &&
                                       vflag_q[v][sva_pkg::FL_FROMKEYS];
        sva_pkg::SW_RELEASE: qual[v] = en[v] && vflag_q[v][sva_pkg::FL_GATED] &&
                                       !vflag_q[v][sva_pkg::FL_PRESSED];
        default:             qual[v] = root_hit_v[v];
      endcase
    end
  end

  always_comb begin
    sw_last = 1'b1;
    for (int v = 0; v < sva_pkg::VOICES; v++) begin
      if (v > int'(sv) && qual[v]) sw_last = 1'b0;
    end
  end

  assign sw_emit = (cmd_i.sw_kind != sva_pkg::SW_OFF) || !hold_q;
  assign sw_fire = cmd_i.sw_step && qual[sv] && sw_emit;
  assign emit    = cmd_i.pat_emit || sw_fire;

  always_comb begin
    if (cmd_i.pat_emit) begin
      out_d.out_note     = played;
      out_d.out_gate     = 1'b1;
      out_d.out_voice    = cur_v_q;
      out_d.out_velocity = g_vel_q;
      out_d.out_legato   = g_leg_q;
      out_d.out_last     = (cmd_i.pat_idx == plen - 1'b1);
    end else begin
      out_d.out_note     = vnote_q[sv];
      out_d.out_gate     = 1'b0;
      out_d.out_voice    = sv;
      out_d.out_velocity = (cmd_i.sw_kind == sva_pkg::SW_OFF) ?
                           lat_q.strike_velocity : vvel_q[sv];
      out_d.out_legato   = 1'b0;
      out_d.out_last     = sw_last;
    end
  end

  // Input word, key memory and output word (no reset; held bits gate every read).
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) lat_q <= in_data_i;
    if (cmd_i.key_write) kmem[lat_q.key_number] <= {lat_q.tick, lat_q.strike_velocity};
    krd_q <= kmem[sk];
    if (emit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ev_en_q     <= 1'b0;
      ev_key_q    <= '0;
    end else begin
      ev_en_q  <= cmd_i.ks_issue;
      ev_key_q <= sk;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Key and voice state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      hold_q <= 1'b0;
      for (int v = 0; v < sva_pkg::VOICES; v++) begin
        vtime_q[v] <= '0;
        vvel_q[v]  <= '0;
        vroot_q[v] <= '0;
        vnote_q[v] <= '0;
        vflag_q[v] <= '0;
      end
    end else begin
      if (cmd_i.panic) begin
        held_q <= '0;
        hold_q <= 1'b0;
        for (int v = 0; v < sva_pkg::VOICES; v++) begin
          vtime_q[v] <= '0;
          vvel_q[v]  <= '0;
          vroot_q[v] <= '0;
          vnote_q[v] <= '0;
          vflag_q[v] <= '0;
        end
      end
      if (cmd_i.key_write) begin
        held_q[lat_q.key_number] <= lat_q.key_down && (lat_q.tick != sva_pkg::TIME_NONE);
      end
      if (cmd_i.alloff_clear) begin
        held_q <= '0;
        hold_q <= 1'b0;
      end
      if (cmd_i.hold_set) hold_q <= lat_q.hold_on;
      if (cmd_i.voice_done && vi_ok) begin
        vflag_q[lat_q.voice_index][sva_pkg::FL_ALLOC]   <= 1'b0;
        vflag_q[lat_q.voice_index][sva_pkg::FL_PRESSED] <= 1'b0;
        vnote_q[lat_q.voice_index] <= sva_pkg::NO_NOTE;
        vroot_q[lat_q.voice_index] <= sva_pkg::NO_NOTE;
      end
      if (cmd_i.pat_emit) begin
        vflag_q[cur_v_q] <= {lat_q.from_keys, 3'b111};
        vvel_q[cur_v_q]  <= g_vel_q;
        vroot_q[cur_v_q] <= {1'b0, g_note_q};
        vnote_q[cur_v_q] <= played;
        vtime_q[cur_v_q] <= lat_q.tick;
      end
      if (cmd_i.sw_step && qual[sv]) begin
        unique case (cmd_i.sw_kind)
          sva_pkg::SW_ALLOFF: begin
            vflag_q[sv][sva_pkg::FL_GATED]   <= 1'b0;
            vflag_q[sv][sva_pkg::FL_PRESSED] <= 1'b0;
          end
          sva_pkg::SW_RELEASE: vflag_q[sv][sva_pkg::FL_GATED] <= 1'b0;
          default: begin
            vflag_q[sv][sva_pkg::FL_PRESSED] <= 1'b0;
            if (!hold_q) vflag_q[sv][sva_pkg::FL_GATED] <= 1'b0;
          end
        endcase
      end
    end
  end

  // Gate-on source, voice search and key scan accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_note_q    <= '0;
      g_vel_q     <= '0;
      g_leg_q     <= 1'b0;
      cur_v_q     <= '0;
      fm_found_q  <= 1'b0;
      fm_v_q      <= '0;
      acc_found_q <= 1'b0;
      acc_v_q     <= '0;
      acc_time_q  <= '1;
      acc_note_q  <= '0;
      ks_found_q  <= 1'b0;
      ks_abort_q  <= 1'b0;
      ks_key_q    <= '0;
      ks_vel_q    <= '0;
      ks_ts_q     <= '0;
    end else begin
      if (cmd_i.gon_init) begin
        g_note_q <= lat_q.key_number;
        g_vel_q  <= lat_q.strike_velocity;
        g_leg_q  <= 1'b0;
      end
      if (cmd_i.restore) begin
        g_note_q <= ks_key_q;
        g_vel_q  <= ks_vel_q;
        g_leg_q  <= 1'b1;
      end
      if (cmd_i.set_v0) cur_v_q <= '0;
      if (cmd_i.pick_v) cur_v_q <= fm_found_q ? fm_v_q : acc_v_q;
      if (cmd_i.pat_emit) cur_v_q <= sva_pkg::next_voice(cur_v_q, en);

      if (cmd_i.vs_init) begin
        fm_found_q  <= 1'b0;
        acc_found_q <= 1'b0;
        acc_time_q  <= '1;
        acc_note_q  <= {1'b0, g_note_q};
      end else if (cmd_i.vs_step && en[sv]) begin
        unique case (cmd_i.vs_mode)
          sva_pkg::VS_FREE: begin
            if (vflag_q[sv][sva_pkg::FL_ALLOC]) begin
              if (vtime_q[sv] < lat_q.tick && vnote_q[sv] == {1'b0, g_note_q} &&
                  !fm_found_q) begin
                fm_found_q <= 1'b1;
                fm_v_q     <= sv;
              end
            end else if (vtime_q[sv] < acc_time_q) begin
              acc_found_q <= 1'b1;
              acc_v_q     <= sv;
              acc_time_q  <= vtime_q[sv];
            end
          end
          sva_pkg::VS_STEAL1: begin
            if (!root_held && vtime_q[sv] < acc_time_q) begin
              acc_found_q <= 1'b1;
              acc_v_q     <= sv;
              acc_time_q  <= vtime_q[sv];
            end
          end
          default: begin
            priority if (prio == sva_pkg::PRIO_LOW) begin
              if (vnote_q[sv] > acc_note_q) begin
                acc_found_q <= 1'b1;
                acc_v_q     <= sv;
                acc_note_q  <= vnote_q[sv];
              end
            end else if (prio == sva_pkg::PRIO_HIGH) begin
              if (vnote_q[sv] < acc_note_q) begin
                acc_found_q <= 1'b1;
                acc_v_q     <= sv;
                acc_note_q  <= vnote_q[sv];
              end
            end else begin
              if (vtime_q[sv] < acc_time_q) begin
                acc_found_q <= 1'b1;
                acc_v_q     <= sv;
                acc_time_q  <= vtime_q[sv];
              end
            end
          end
        endcase
      end

      if (cmd_i.ks_init) begin
        ks_found_q <= 1'b0;
        ks_abort_q <= 1'b0;
        ks_ts_q    <= '0;
      end else if (ev_en_q) begin
        if (cmd_i.ks_mode == sva_pkg::KS_MONO) begin
          if (ev_key_q != g_note_q && held_q[ev_key_q]) begin
            if (prio == sva_pkg::PRIO_LOW && g_note_q > ev_key_q) ks_abort_q <= 1'b1;
            if (prio == sva_pkg::PRIO_HIGH && g_note_q < ev_key_q) ks_abort_q <= 1'b1;
            g_leg_q <= 1'b1;
          end
        end else if (held_q[ev_key_q] && !(|ev_rooted_v)) begin
          // Last-note takes the newest free key; low/high take the first one met.
          if (prio == sva_pkg::PRIO_LAST) begin
            if (krd_time > ks_ts_q) begin
              ks_found_q <= 1'b1;
              ks_key_q   <= ev_key_q;
              ks_vel_q   <= krd_vel;
              ks_ts_q    <= krd_time;
            end
          end else if (!ks_found_q) begin
            ks_found_q <= 1'b1;
            ks_key_q   <= ev_key_q;
            ks_vel_q   <= krd_vel;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.op       = lat_q.opcode;
    sts_o.key_down = lat_q.key_down;
    sts_o.hold_on  = lat_q.hold_on;
    sts_o.any_en   = |en;
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.root_hit = |root_hit_v;
    sts_o.pick_ok  = fm_found_q || acc_found_q;
    sts_o.ks_found = ks_found_q;
    sts_o.ks_abort = ks_abort_q;
    sts_o.sw_qual  = qual;
    sts_o.sw_emit  = sw_emit;
    sts_o.pat_len  = plen;
  end

endmodule

@@ sv/sva_ctrl.sv @@
// Controller state machine: sequences searches, scans and result words.
module sva_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sva_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sva_pkg::sts_t  sts_i,
  output sva_pkg::cmd_t  cmd_o
);

  sva_pkg::state_e             state_q, state_d;
  logic [sva_pkg::VIDX_W-1:0]  vc_q, vc_d;
  logic [sva_pkg::KC_W-1:0]    kc_q, kc_d;
  logic [sva_pkg::PAT_W-1:0]   pi_q, pi_d;
  sva_pkg::vscan_e             vmode_q, vmode_d;
  sva_pkg::kscan_e             kmode_q, kmode_d;
  sva_pkg::sweep_e             swk_q, swk_d;
  logic                        prio_last;
  logic                        vlast;
  logic                        sw_wait;

  assign prio_last = sva_pkg::prio_norm(cfg_i.priority_mode) == sva_pkg::PRIO_LAST;
  assign vlast     = vc_q == sva_pkg::VIDX_W'(sva_pkg::VOICES - 1);
  assign sw_wait   = sts_i.sw_qual[vc_q] && sts_i.sw_emit && !sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sva_pkg::S_IDLE;
      vc_q    <= '0;
      kc_q    <= '0;
      pi_q    <= '0;
      vmode_q <= sva_pkg::VS_FREE;
      kmode_q <= sva_pkg::KS_MONO;
      swk_q   <= sva_pkg::SW_OFF;
    end else begin
      state_q <= state_d;
      vc_q    <= vc_d;
      kc_q    <= kc_d;
      pi_q    <= pi_d;
      vmode_q <= vmode_d;
      kmode_q <= kmode_d;
      swk_q   <= swk_d;
    end
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    vc_d    = vc_q;
    kc_d    = kc_q;
    pi_d    = pi_q;
    vmode_d = vmode_q;
    kmode_d = kmode_q;
    swk_d   = swk_q;
    unique case (state_q)
      sva_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sva_pkg::S_DISPATCH;
      end
      sva_pkg::S_DISPATCH: begin
        vc_d = '0;
        unique case (sts_i.op)
          sva_pkg::OP_NOTE: state_d = sts_i.key_down ? sva_pkg::S_GON : sva_pkg::S_NOFF;
          sva_pkg::OP_ALLOFF: begin
            swk_d   = sva_pkg::SW_ALLOFF;
            state_d = sva_pkg::S_SWEEP;
          end
          sva_pkg::OP_HOLD: begin
            swk_d   = sva_pkg::SW_RELEASE;
            state_d = sts_i.hold_on ? sva_pkg::S_IDLE : sva_pkg::S_SWEEP;
          end
          default: state_d = sva_pkg::S_IDLE;
        endcase
      end
      sva_pkg::S_GON: begin
        kc_d = '0;
        vc_d = '0;
        pi_d = '0;
        priority if (!sts_i.any_en) begin
          state_d = sva_pkg::S_IDLE;
        end else if (cfg_i.mono_mode) begin
          kmode_d = sva_pkg::KS_MONO;
          state_d = prio_last ? sva_pkg::S_PATTERN : sva_pkg::S_KSCAN;
        end else begin
          vmode_d = sva_pkg::VS_FREE;
          state_d = sva_pkg::S_VSCAN;
        end
      end
      sva_pkg::S_VSCAN: begin
        if (vlast) state_d = sva_pkg::S_VPICK;
        else vc_d = vc_q + 1'b1;
      end
      sva_pkg::S_VPICK: begin
        vc_d = '0;
        pi_d = '0;
        priority if (sts_i.pick_ok) begin
          state_d = sva_pkg::S_PATTERN;
        end else if (vmode_q == sva_pkg::VS_FREE) begin
          vmode_d = sva_pkg::VS_STEAL1;
          state_d = sva_pkg::S_VSCAN;
        end else if (vmode_q == sva_pkg::VS_STEAL1) begin
          vmode_d = sva_pkg::VS_STEAL2;
          state_d = sva_pkg::S_VSCAN;
        end else begin
          state_d = sva_pkg::S_IDLE;
        end
      end
      sva_pkg::S_NOFF: begin
        kc_d    = '0;
        kmode_d = sva_pkg::KS_OFF;
        state_d = sts_i.root_hit ? sva_pkg::S_KSCAN : sva_pkg::S_IDLE;
      end
      sva_pkg::S_KSCAN: begin
        // The extra step at a count of KEYS lets the last memory read land.
        if (kc_q == sva_pkg::KC_W'(sva_pkg::KEYS)) state_d = sva_pkg::S_KDONE;
        else kc_d = kc_q + 1'b1;
      end
      sva_pkg::S_KDONE: begin
        pi_d = '0;
        vc_d = '0;
        if (kmode_q == sva_pkg::KS_MONO) begin
          state_d = sts_i.ks_abort ? sva_pkg::S_IDLE : sva_pkg::S_PATTERN;
        end else if (sts_i.ks_found) begin
          state_d = sva_pkg::S_GON;
        end else begin
          swk_d   = sva_pkg::SW_OFF;
          state_d = sva_pkg::S_SWEEP;
        end
      end
      sva_pkg::S_PATTERN: begin
        if (pi_q >= sts_i.pat_len) begin
          state_d = sva_pkg::S_IDLE;
        end else if (sts_i.out_free) begin
          if (pi_q == sts_i.pat_len - 1'b1) state_d = sva_pkg::S_IDLE;
          else pi_d = pi_q + 1'b1;
        end
      end
      sva_pkg::S_SWEEP: begin
        if (!sw_wait) begin
          if (vlast) state_d = sva_pkg::S_IDLE;
          else vc_d = vc_q + 1'b1;
        end
      end
      default: state_d = sva_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.vs_mode  = vmode_q;
    cmd_o.ks_mode  = kmode_q;
    cmd_o.sw_kind  = swk_q;
    cmd_o.v_idx    = vc_q;
    cmd_o.ks_addr  = kc_q[sva_pkg::KEY_W-1:0];
    cmd_o.pat_idx  = pi_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      sva_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      sva_pkg::S_DISPATCH: begin
        unique case (sts_i.op)
          sva_pkg::OP_NOTE: begin
            cmd_o.key_write = 1'b1;
            cmd_o.gon_init  = sts_i.key_down;
          end
          sva_pkg::OP_DONE:   cmd_o.voice_done   = 1'b1;
          sva_pkg::OP_ALLOFF: cmd_o.alloff_clear = 1'b1;
          sva_pkg::OP_HOLD:   cmd_o.hold_set     = 1'b1;
          sva_pkg::OP_PANIC:  cmd_o.panic        = 1'b1;
          default: ;
        endcase
      end
      sva_pkg::S_GON: begin
        if (sts_i.any_en) begin
          if (cfg_i.mono_mode) begin
            cmd_o.set_v0  = 1'b1;
            cmd_o.ks_init = 1'b1;
          end else begin
            cmd_o.vs_init = 1'b1;
            cmd_o.vs_mode = sva_pkg::VS_FREE;
          end
        end
      end
      sva_pkg::S_VSCAN: cmd_o.vs_step = 1'b1;
      sva_pkg::S_VPICK: begin
        if (sts_i.pick_ok) begin
          cmd_o.pick_v = 1'b1;
        end else begin
          cmd_o.vs_init = 1'b1;
          cmd_o.vs_mode = (vmode_q == sva_pkg::VS_FREE) ? sva_pkg::VS_STEAL1 :
                                                          sva_pkg::VS_STEAL2;
        end
      end
      sva_pkg::S_NOFF:  cmd_o.ks_init  = 1'b1;
      sva_pkg::S_KSCAN: cmd_o.ks_issue = kc_q < sva_pkg::KC_W'(sva_pkg::KEYS);
      sva_pkg::S_KDONE: begin
        cmd_o.restore = (kmode_q == sva_pkg::KS_OFF) && sts_i.ks_found;
      end
      sva_pkg::S_PATTERN: cmd_o.pat_emit = (pi_q < sts_i.pat_len) && sts_i.out_free;
      sva_pkg::S_SWEEP:   cmd_o.sw_step  = !sw_wait;
      default: ;
    endcase
  end

  a_pat_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pat_emit |-> sts_i.out_free)
    else $error("gate-on word issued into a full output register");

  a_sweep_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sw_step && sts_i.sw_qual[vc_q] && sts_i.sw_emit) |-> sts_i.out_free)
    else $error("gate-off word issued into a full output register");

  a_latch_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> state_q == sva_pkg::S_DISPATCH)
    else $error("accepted word not dispatched");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sva_pkg::S_KSCAN && kc_q == sva_pkg::KC_W'(sva_pkg::KEYS))
      |=> state_q == sva_pkg::S_KDONE)
    else $error("key scan overran the key range");

endmodule

@@ sv/synth_voice_assigner.sv @@
// Voice assigner top level: registers, controller and datapath.
//
// Input words arrive on in_valid_i/in_ready_o and carry one event: note,
// voice done, all keys off, hold or panic. Each event yields zero to six
// result words on out_valid_o/out_ready_i, the final one flagged out_last.
// Configuration is to be written through the APB port only while the block is
// idle; the block itself does not enforce this. One event is in work at a time.
// A note-on's free-voice search can fall through to both steal passes (six
// voices checked one per cycle per pass). Low/high priority mono adds a key
// scan. A note-off that hits a sounding voice scans all 128 keys, one per
// cycle from the key memory, and restoring a held key can add a second
// gate-on search.
// Reset clears all held keys and voice state and loads register defaults.
// A result word waits in the output register while the receiver stalls;
// the block holds its next result until that word is taken, and the next
// input word can be accepted once the last result is registered.
module synth_voice_assigner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sva_pkg::in_word_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sva_pkg::out_word_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sva_pkg::ADDR_W-1:0] paddr,
  input  logic [sva_pkg::DATA_W-1:0] pwdata,
  output logic [sva_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sva_pkg::cfg_t cfg;
  sva_pkg::cmd_t cmd;
  sva_pkg::sts_t sts;

  sva_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sva_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for the voice assigner: event stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 320;
  localparam int ITEMS_PER_SET  = 38;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  sva_pkg::in_word_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  sva_pkg::out_word_t out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [sva_pkg::ADDR_W-1:0] paddr = '0;
  logic [sva_pkg::DATA_W-1:0] pwdata = '0;
  logic [sva_pkg::DATA_W-1:0] prdata;
  logic        pready;

  synth_voice_assigner dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  class voice_scoreboard;
    logic [1:0]  prio_code;
    logic [5:0]  voice_mask;
    logic        mono;
    logic [47:0] pattern;

    logic [31:0] key_time[sva_pkg::KEYS];
    logic [15:0] key_vel[sva_pkg::KEYS];
    logic [31:0] v_time[sva_pkg::VOICES];
    logic [15:0] v_vel[sva_pkg::VOICES];
    logic [7:0]  v_root[sva_pkg::VOICES];
    logic [7:0]  v_note[sva_pkg::VOICES];
    logic [3:0]  v_flags[sva_pkg::VOICES];
    logic        hold;

    sva_pkg::out_word_t step_events[$];
    sva_pkg::out_word_t expected_events[$];
    int          mismatches;
    int          results_seen;
    int          inputs_seen;

    function new();
      prio_code  = 2'd0;
      voice_mask = 6'd63;
      mono       = 1'b0;
      pattern    = 48'hFFFF_FFFF_FF00;
      mismatches = 0;
      results_seen = 0;
      inputs_seen  = 0;
      clear_voices();
    endfunction

    function void clear_voices();
      for (int k = 0; k < sva_pkg::KEYS; k++) begin
        key_time[k] = '1;
        key_vel[k]  = '0;
      end
      for (int v = 0; v < sva_pkg::VOICES; v++) begin
        v_time[v] = '0; v_vel[v] = '0; v_root[v] = '0; v_note[v] = '0; v_flags[v] = '0;
      end
      hold = 1'b0;
    endfunction

    function void set_reg(sva_pkg::reg_e r, logic [63:0] val);
      case (r)
        sva_pkg::REG_PRIO: prio_code  = val[1:0];
        sva_pkg::REG_MASK: voice_mask = val[5:0];
        sva_pkg::REG_MONO: mono       = val[0];
        sva_pkg::REG_PAT:  pattern    = val[47:0];
      endcase
    endfunction

    // Code three falls back to last-note priority.
    function sva_pkg::prio_e eff_prio();
      if (prio_code == 2'd1) return sva_pkg::PRIO_LOW;
      if (prio_code == 2'd2) return sva_pkg::PRIO_HIGH;
      return sva_pkg::PRIO_LAST;
    endfunction

    function bit usable(int v);
      return v >= 0 && v < sva_pkg::VOICES && voice_mask[v];
    endfunction

    function bit key_is_down(int k);
      return k < sva_pkg::KEYS && key_time[k] != '1;
    endfunction

    function void add_event(int note, bit gate, int v, int vel, bit leg);
      sva_pkg::out_word_t e;
      e.out_note     = note[7:0];
      e.out_gate     = gate;
      e.out_voice    = v[2:0];
      e.out_velocity = vel[15:0];
      e.out_legato   = leg;
      e.out_last     = 1'b0;
      step_events.push_back(e);
    endfunction

    function int voice_of_root(int key);
      for (int v = 0; v < sva_pkg::VOICES; v++)
        if (usable(v) && v_flags[v][sva_pkg::FL_ALLOC] && v_root[v] == key) return v;
      return -1;
    endfunction

    function int pick_free(int note, logic [31:0] tk);
      int best;
      logic [31:0] oldest;
      best = -1;
      oldest = '1;
      for (int v = 0; v < sva_pkg::VOICES; v++) begin
        if (!usable(v)) continue;
        if (v_flags[v][sva_pkg::FL_ALLOC]) begin
          if (v_time[v] < tk && v_note[v] == note) return v;
        end else if (v_time[v] < oldest) begin
          oldest = v_time[v];
          best = v;
        end
      end
      return best;
    endfunction

    function int pick_steal(int note);
      int best;
      logic [31:0] ts;
      int thr;
      best = -1;
      ts = '1;
      thr = note;
      for (int v = 0; v < sva_pkg::VOICES; v++)
        if (usable(v) && !key_is_down(v_root[v]) && v_time[v] < ts) begin
          ts = v_time[v];
          best = v;
        end
      if (best >= 0) return best;
      ts = '1;
      for (int v = 0; v < sva_pkg::VOICES; v++) begin
        if (!usable(v)) continue;
        case (eff_prio())
          sva_pkg::PRIO_LAST: if (v_time[v] < ts) begin best = v; ts = v_time[v]; end
          sva_pkg::PRIO_LOW:  if (v_note[v] > thr) begin best = v; thr = v_note[v]; end
          default:            if (v_note[v] < thr) begin best = v; thr = v_note[v]; end
        endcase
      end
      return best;
    endfunction

    function void start_notes(int note, int vel, bit fk, logic [31:0] tk, bit leg);
      int v;
      int played;
      logic [7:0] off;
      if (voice_mask == '0) return;
      if (mono) begin
        v = 0;
        if (eff_prio() != sva_pkg::PRIO_LAST)
          for (int k = 0; k < sva_pkg::KEYS; k++) begin
            if (k == note || !key_is_down(k)) continue;
            if (note > k && eff_prio() == sva_pkg::PRIO_LOW) return;
            if (note < k && eff_prio() == sva_pkg::PRIO_HIGH) return;
            leg = 1'b1;
          end
      end else begin
        v = pick_free(note, tk);
        if (v < 0) v = pick_steal(note);
        if (v < 0) return;
      end
      for (int i = 0; i < sva_pkg::VOICES && i < 6; i++) begin
        off = pattern[8*i +: 8];
        if (off == 8'hFF) break;
        played = (note + off) & 255;
        v_flags[v] = 4'b0111 | (fk ? 4'b1000 : 4'b0000);
        v_vel[v]   = vel[15:0];
        v_root[v]  = note[7:0];
        v_note[v]  = played[7:0];
        v_time[v]  = tk;
        add_event(played, 1'b1, v, vel, leg);
        do v = (v + 1) % sva_pkg::VOICES; while (!usable(v));
      end
    endfunction

    function void release_key(int key, int vel, bit fk, logic [31:0] tk);
      bit found;
      int rk, rv;
      logic [31:0] rts;
      int c;
      found = 1'b0; rk = 0; rv = 0; rts = '0;
      if (voice_of_root(key) < 0) return;
      if (eff_prio() == sva_pkg::PRIO_LAST) begin
        for (int k = 0; k < sva_pkg::KEYS; k++)
          if (key_is_down(k) && key_time[k] > rts && voice_of_root(k) < 0) begin
            found = 1'b1; rk = k; rv = key_vel[k]; rts = key_time[k];
          end
      end else begin
        for (int k = 0; k < sva_pkg::KEYS; k++) begin
          c = (eff_prio() == sva_pkg::PRIO_HIGH) ? (sva_pkg::KEYS - 1 - k) : k;
          if (key_is_down(c) && voice_of_root(c) < 0) begin
            found = 1'b1; rk = c; rv = key_vel[c];
            break;
          end
        end
      end
      if (found) begin
        start_notes(rk, rv, fk, tk, 1'b1);
        return;
      end
      for (int v = 0; v < sva_pkg::VOICES; v++) begin
        if (!usable(v) || !v_flags[v][sva_pkg::FL_ALLOC] || v_root[v] != key) continue;
        v_flags[v][sva_pkg::FL_PRESSED] = 1'b0;
        if (!hold) begin
          v_flags[v][sva_pkg::FL_GATED] = 1'b0;
          add_event(v_note[v], 1'b0, v, vel, 1'b0);
        end
      end
    endfunction

    function void note_input(sva_pkg::in_word_t w);
      int vi;
      inputs_seen++;
      step_events.delete();
      vi = w.voice_index;
      case (w.opcode)
        sva_pkg::OP_NOTE: begin
          key_vel[w.key_number]  = w.strike_velocity;
          key_time[w.key_number] = w.key_down ? w.tick : '1;
          if (w.key_down)
            start_notes(w.key_number, w.strike_velocity, w.from_keys, w.tick, 1'b0);
          else
            release_key(w.key_number, w.strike_velocity, w.from_keys, w.tick);
        end
        sva_pkg::OP_DONE:
          if (vi < sva_pkg::VOICES) begin
            v_flags[vi][sva_pkg::FL_ALLOC]   = 1'b0;
            v_flags[vi][sva_pkg::FL_PRESSED] = 1'b0;
            v_note[vi] = sva_pkg::NO_NOTE;
            v_root[vi] = sva_pkg::NO_NOTE;
          end
        sva_pkg::OP_ALLOFF: begin
          for (int v = 0; v < sva_pkg::VOICES; v++)
            if (usable(v) && v_flags[v][sva_pkg::FL_GATED] &&
                v_flags[v][sva_pkg::FL_FROMKEYS]) begin
              add_event(v_note[v], 1'b0, v, v_vel[v], 1'b0);
              v_flags[v][sva_pkg::FL_GATED]   = 1'b0;
              v_flags[v][sva_pkg::FL_PRESSED] = 1'b0;
            end
          for (int k = 0; k < sva_pkg::KEYS; k++) key_time[k] = '1;
          hold = 1'b0;
        end
        sva_pkg::OP_HOLD: begin
          hold = w.hold_on;
          if (!w.hold_on)
            for (int v = 0; v < sva_pkg::VOICES; v++)
              if (usable(v) && v_flags[v][sva_pkg::FL_GATED] &&
                  !v_flags[v][sva_pkg::FL_PRESSED]) begin
                add_event(v_note[v], 1'b0, v, v_vel[v], 1'b0);
                v_flags[v][sva_pkg::FL_GATED] = 1'b0;
              end
        end
        sva_pkg::OP_PANIC: clear_voices();
        default: ;
      endcase
      if (step_events.size() > 0) step_events[step_events.size() - 1].out_last = 1'b1;
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task check_result(sva_pkg::out_word_t got);
      sva_pkg::out_word_t exp;
      results_seen++;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      exp = expected_events.pop_front();
      if (got.out_note !== exp.out_note)
        report($sformatf("note %0d, want %0d", got.out_note, exp.out_note));
      if (got.out_gate !== exp.out_gate)
        report($sformatf("gate %0d, want %0d", got.out_gate, exp.out_gate));
      if (got.out_voice !== exp.out_voice)
        report($sformatf("voice %0d, want %0d", got.out_voice, exp.out_voice));
      if (got.out_velocity !== exp.out_velocity)
        report($sformatf("velocity %0d, want %0d", got.out_velocity, exp.out_velocity));
      if (got.out_legato !== exp.out_legato)
        report($sformatf("legato %0d, want %0d", got.out_legato, exp.out_legato));
      if (got.out_last !== exp.out_last)
        report($sformatf("last %0d, want %0d", got.out_last, exp.out_last));
    endtask
  endclass

  voice_scoreboard sb = new();

  logic [31:0] now_tick = 32'd0;
  int          down_keys[$];
  bit          long_hold = 1'b0;
  int          idle_cycles = 0;

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (500) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  task automatic send_word(sva_pkg::in_word_t w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
  endtask

  // Build an event word and track which keys are down.
  task automatic send_event(sva_pkg::op_e op, int key, bit down, int vel, bit fk, int vi,
                            bit hold_on);
    sva_pkg::in_word_t w;
    bit burst;
    now_tick = now_tick + $urandom_range(1, 900);
    if (now_tick == 32'hFFFF_FFFF) now_tick = 32'd5;
    w = '0;
    w.opcode          = op;
    w.key_number      = key[6:0];
    w.key_down        = down;
    w.strike_velocity = vel[15:0];
    w.from_keys       = fk;
    w.voice_index     = vi[2:0];
    w.hold_on         = hold_on;
    w.tick            = now_tick;
    burst = ($urandom_range(0, 4) == 0);
    send_word(w, burst);
    if (op == sva_pkg::OP_NOTE) begin
      foreach (down_keys[i]) if (down_keys[i] == key) begin down_keys.delete(i); break; end
      if (down) down_keys.push_back(key);
    end else if (op == sva_pkg::OP_ALLOFF || op == sva_pkg::OP_PANIC) begin
      down_keys.delete();
    end
  endtask

  task automatic write_reg(sva_pkg::reg_e r, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, val);
  endtask

  task automatic drain(bit settle);
    in_valid_i <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] pr, logic [5:0] mask, bit mono, logic [47:0] pat);
    drain(1'b1);
    write_reg(sva_pkg::REG_PRIO, 64'(pr));
    write_reg(sva_pkg::REG_MASK, 64'(mask));
    write_reg(sva_pkg::REG_MONO, 64'(mono));
    write_reg(sva_pkg::REG_PAT, 64'(pat));
  endtask

  // Mostly note on/off pairs over a narrow key band, with the other events mixed in.
  task automatic random_events(int count);
    int sel, key;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      key = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(55, 67);
      if (sel < 44)
        send_event(sva_pkg::OP_NOTE, key, 1'b1, $urandom, 1'($urandom), $urandom,
                   1'($urandom));
      else if (sel < 78) begin
        if (down_keys.size() > 0 && sel < 72)
          key = down_keys[$urandom_range(0, down_keys.size() - 1)];
        send_event(sva_pkg::OP_NOTE, key, 1'b0, $urandom, 1'($urandom), $urandom,
                   1'($urandom));
      end else if (sel < 85)
        send_event(sva_pkg::OP_DONE, key, 1'($urandom), $urandom, 1'($urandom),
                   $urandom_range(0, 7), 1'($urandom));
      else if (sel < 88)
        send_event(sva_pkg::OP_ALLOFF, key, 1'($urandom), $urandom, 1'($urandom),
                   $urandom, 1'($urandom));
      else if (sel < 96)
        send_event(sva_pkg::OP_HOLD, key, 1'($urandom), $urandom, 1'($urandom),
                   $urandom, 1'($urandom));
      else if (sel < 98)
        send_event(sva_pkg::OP_PANIC, key, 1'($urandom), $urandom, 1'($urandom),
                   $urandom, 1'($urandom));
      else
        send_event(sva_pkg::op_e'($urandom_range(5, 7)), key, 1'b1, $urandom, 1'b1, 0,
                   1'b0);
    end
  endtask

  initial begin : stimulus
    sva_pkg::in_word_t w;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every event kind, hold, stealing, odd opcodes.
    send_event(sva_pkg::OP_NOTE, 0, 1'b1, 0, 1'b0, 0, 1'b0);
    send_event(sva_pkg::OP_NOTE, 127, 1'b1, 16'hFFFF, 1'b1, 7, 1'b1);
    send_event(sva_pkg::OP_NOTE, 127, 1'b1, 16'h1234, 1'b1, 0, 1'b0);
    for (int k = 60; k < 66; k++) send_event(sva_pkg::OP_NOTE, k, 1'b1, 100 + k, 1'b1, 0, 1'b0);
    send_event(sva_pkg::OP_NOTE, 64, 1'b0, 16'h00FF, 1'b1, 0, 1'b0);
    send_event(sva_pkg::OP_HOLD, 0, 1'b0, 0, 1'b0, 0, 1'b1);
    send_event(sva_pkg::OP_NOTE, 61, 1'b0, 77, 1'b1, 0, 1'b0);
    send_event(sva_pkg::OP_HOLD, 0, 1'b0, 0, 1'b0, 0, 1'b0);
    send_event(sva_pkg::OP_DONE, 0, 1'b0, 0, 1'b0, 7, 1'b0);
    send_event(sva_pkg::OP_DONE, 0, 1'b0, 0, 1'b0, 6, 1'b0);
    send_event(sva_pkg::OP_DONE, 0, 1'b0, 0, 1'b0, 2, 1'b0);
    send_event(sva_pkg::OP_ALLOFF, 0, 1'b0, 0, 1'b0, 0, 1'b0);
    send_event(sva_pkg::op_e'(3'd5), 5, 1'b1, 1, 1'b1, 1, 1'b1);
    send_event(sva_pkg::op_e'(3'd7), 5, 1'b1, 1, 1'b1, 1, 1'b1);
    // Key-down with an all-ones stamp leaves the key released.
    w = '0;
    w.opcode = sva_pkg::OP_NOTE; w.key_number = 7'd40; w.key_down = 1'b1;
    w.strike_velocity = 16'h8001; w.tick = '1;
    send_word(w, 1'b0);
    send_event(sva_pkg::OP_NOTE, 40, 1'b0, 3, 1'b0, 0, 1'b0);
    send_event(sva_pkg::OP_PANIC, 0, 1'b0, 0, 1'b0, 0, 1'b0);
    random_events(ITEMS_PER_SET - 20);

    configure(2'd0, 6'd63, 1'b0, 48'hFFFF_FFFF_0704);
    random_events(ITEMS_PER_SET);

    configure(2'd1, 6'h2A, 1'b0, 48'h0);
    random_events(ITEMS_PER_SET / 2);
    long_hold = 1'b1;
    random_events(ITEMS_PER_SET / 2);
    drain(1'b0);
    random_events(8);

    configure(2'd2, 6'd63, 1'b1, 48'hFFFF_FFFF_FF00);
    random_events(ITEMS_PER_SET);

    configure(2'd3, 6'd0, 1'b0, 48'({$urandom, $urandom}));
    random_events(ITEMS_PER_SET / 2);

    configure(2'd1, 6'h3E, 1'b1, 48'hFFFF_FFFF_0C00);
    random_events(ITEMS_PER_SET);

    configure(2'd2, 6'($urandom_range(1, 63)), 1'b0, 48'({$urandom, $urandom}));
    random_events(ITEMS_PER_SET);

    configure(2'd0, 6'd63, 1'b0, 48'hFFFF_FFFF_FFFF);
    random_events(10);
    configure(2'd0, 6'd63, 1'b0, 48'hFFFF_0018_0C00);
    random_events(ITEMS_PER_SET);

    drain(1'b1);
    if (sb.expected_events.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_events.size()));
    $display("covered %0d events and %0d result words over nine register settings",
             sb.inputs_seen, sb.results_seen);
    $display("mono and poly modes, all priorities, masks from none to all voices");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sva_pkg.sv
sv/sva_regs.sv
sv/sva_datapath.sv
sv/sva_ctrl.sv
sv/synth_voice_assigner.sv
verif/tb_top.sv
